/* hw/rtl/cpr_pkg.sv */
`default_nettype none

package cpr_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam logic [15:0] PERIOD_RESET = 16'd300;

    // Enough decimal digits for any sample of up to 16 bits
    localparam int MAX_DIGITS = 5;
    localparam int POS_W = $clog2(MAX_DIGITS);
    localparam int CMP_W = 17;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] PREFIX_LAST = IDX_W'(4);
    localparam logic [IDX_W-1:0] SUFFIX_LAST = IDX_W'(2);

    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [6:0] {
        RZ_IDLE  = 7'b0000001,
        RZ_START = 7'b0000010,
        RZ_R     = 7'b0000100,
        RZ_RS    = 7'b0001000,
        RZ_RST   = 7'b0010000,
        RZ_O     = 7'b0100000,
        RZ_OK    = 7'b1000000
    } t_rz_state;

    typedef enum logic [3:0] {
        SD_IDLE   = 4'b0001,
        SD_SEND   = 4'b0010,
        SD_WAIT   = 4'b0100,
        SD_RESEND = 4'b1000
    } t_sd_state;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_DIGIT  = 4'b0100,
        PH_SUFFIX = 4'b1000
    } t_phase;

    function automatic logic [CMP_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [CMP_W-1:0] p;
        unique case (pos)
            POS_W'(0): p = CMP_W'(1);
            POS_W'(1): p = CMP_W'(10);
            POS_W'(2): p = CMP_W'(100);
            POS_W'(3): p = CMP_W'(1000);
            POS_W'(4): p = CMP_W'(10000);
            default:   p = '0;
        endcase
        return p;
    endfunction

    // "!ADC=" without the leading '!', which goes out when the request is taken
    function automatic logic [7:0] prefix_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            IDX_W'(1): c = CH_A;
            IDX_W'(2): c = CH_D;
            IDX_W'(3): c = CH_C;
            IDX_W'(4): c = CH_EQ;
            default:   c = CH_BANG;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] suffix_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            IDX_W'(0): c = CH_HASH;
            IDX_W'(1): c = CH_CR;
            default:   c = CH_LF;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cpr_parser.sv */
`default_nettype none

module cpr_parser #(
    parameter int SAMPLE_BITS = cpr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_op,
    input  wire logic [7:0]             i_rx_byte,
    input  wire logic [SAMPLE_BITS-1:0] i_adc_sample,
    input  wire logic                   i_cfg_we,
    input  wire logic [15:0]            i_cfg_wdata,
    input  wire logic                   i_take,
    output logic                        o_pend_valid,
    output logic [SAMPLE_BITS-1:0]      o_pend_sample
);

    cpr_pkg::t_rz_state r_rz, n_rz;
    cpr_pkg::t_sd_state r_sd, n_sd;
    logic [15:0]            r_period;
    logic [15:0]            r_wait, n_wait;
    logic [SAMPLE_BITS-1:0] r_kept, n_kept;
    logic                   r_pend_valid, n_pend_valid;
    logic [SAMPLE_BITS-1:0] r_pend_sample, n_pend_sample;
    logic                   w_acc;

    // The single response slot frees in the same cycle the serializer takes it
    assign o_in_stall    = r_pend_valid && !i_take;
    assign w_acc         = i_in_valid && !o_in_stall;
    assign o_pend_valid  = r_pend_valid;
    assign o_pend_sample = r_pend_sample;

    always_comb begin
        n_rz          = r_rz;
        n_sd          = r_sd;
        n_wait        = r_wait;
        n_kept        = r_kept;
        n_pend_valid  = r_pend_valid && !i_take;
        n_pend_sample = r_pend_sample;
        if (w_acc && !i_op) begin
            if (i_rx_byte == cpr_pkg::CH_BANG) begin
                n_rz = cpr_pkg::RZ_START;
            end else begin
                unique case (r_rz)
                    cpr_pkg::RZ_START: begin
                        if (i_rx_byte == cpr_pkg::CH_R) n_rz = cpr_pkg::RZ_R;
                        else if (i_rx_byte == cpr_pkg::CH_O) n_rz = cpr_pkg::RZ_O;
                        else n_rz = cpr_pkg::RZ_IDLE;
                    end
                    cpr_pkg::RZ_R: begin
                        n_rz = (i_rx_byte == cpr_pkg::CH_S) ? cpr_pkg::RZ_RS : cpr_pkg::RZ_IDLE;
                    end
                    cpr_pkg::RZ_RS: begin
                        n_rz = (i_rx_byte == cpr_pkg::CH_T) ? cpr_pkg::RZ_RST : cpr_pkg::RZ_IDLE;
                    end
                    cpr_pkg::RZ_RST: begin
                        if (i_rx_byte == cpr_pkg::CH_HASH) n_sd = cpr_pkg::SD_SEND;
                        n_rz = cpr_pkg::RZ_IDLE;
                    end
                    cpr_pkg::RZ_O: begin
                        n_rz = (i_rx_byte == cpr_pkg::CH_K) ? cpr_pkg::RZ_OK : cpr_pkg::RZ_IDLE;
                    end
                    cpr_pkg::RZ_OK: begin
                        if (i_rx_byte == cpr_pkg::CH_HASH) n_sd = cpr_pkg::SD_IDLE;
                        n_rz = cpr_pkg::RZ_IDLE;
                    end
                    default: begin
                        n_rz = cpr_pkg::RZ_IDLE;
                    end
                endcase
            end
        end else if (w_acc && i_op) begin
            unique case (r_sd)
                cpr_pkg::SD_SEND: begin
                    n_pend_valid  = 1'b1;
                    n_pend_sample = i_adc_sample;
                    n_kept        = i_adc_sample;
                    n_wait        = r_period;
                    n_sd          = cpr_pkg::SD_WAIT;
                end
                cpr_pkg::SD_WAIT: begin
                    n_wait = r_wait - 16'd1;
                    if (n_wait == 16'd0) n_sd = cpr_pkg::SD_RESEND;
                end
                cpr_pkg::SD_RESEND: begin
                    n_pend_valid  = 1'b1;
                    n_pend_sample = r_kept;
                    n_wait        = r_period;
                    n_sd          = cpr_pkg::SD_WAIT;
                end
                default: begin
                    n_sd = r_sd;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rz         <= cpr_pkg::RZ_IDLE;
            r_sd         <= cpr_pkg::SD_IDLE;
            r_period     <= cpr_pkg::PERIOD_RESET;
            r_wait       <= '0;
            r_kept       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_rz         <= n_rz;
            r_sd         <= n_sd;
            r_wait       <= n_wait;
            r_kept       <= n_kept;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_we) r_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_sample <= n_pend_sample;
    end

`ifndef ASSERT_OFF
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid && !i_take |=> r_pend_valid && $stable(r_pend_sample))
        else $error("pending response lost or changed");

    a_send_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_op && r_sd == cpr_pkg::SD_SEND
        |=> r_sd == cpr_pkg::SD_WAIT && r_pend_valid && r_wait == r_period)
        else $error("sending tick did not queue a response");

    a_byte_no_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_op |=> !r_pend_valid || $past(r_pend_valid))
        else $error("received byte queued a response");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cpr_serializer.sv */
`default_nettype none

module cpr_serializer #(
    parameter int SAMPLE_BITS = cpr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_pend_valid,
    input  wire logic [SAMPLE_BITS-1:0] i_pend_sample,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [7:0]                  o_tx_byte,
    output logic                        o_last_byte
);

    cpr_pkg::t_phase r_ph, n_ph;
    logic [cpr_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [cpr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [SAMPLE_BITS-1:0]    r_rem, n_rem;
    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_tx_byte, n_tx_byte;
    logic                      r_last, n_last;

    logic                      w_adv;
    logic [cpr_pkg::CMP_W-1:0] w_rem_wide;
    logic [cpr_pkg::CMP_W-1:0] w_pow;
    logic [cpr_pkg::CMP_W-1:0] w_sub;
    logic [3:0]                w_digit;
    logic [cpr_pkg::CMP_W-1:0] w_cand;
    logic [cpr_pkg::POS_W-1:0] w_top_pos;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_take     = w_adv && (r_ph == cpr_pkg::PH_IDLE) && i_pend_valid;
    assign w_rem_wide = cpr_pkg::CMP_W'(r_rem);
    assign w_pow      = cpr_pkg::pow10(r_pos);

    // Digit at the current position: largest multiple of 10^pos not above the remainder
    always_comb begin
        w_digit = 4'd0;
        w_sub   = '0;
        w_cand  = '0;
        for (int m = 1; m <= 9; m++) begin
            w_cand = cpr_pkg::CMP_W'(w_pow * cpr_pkg::CMP_W'(m));
            if (w_rem_wide >= w_cand) begin
                w_digit = 4'(m);
                w_sub   = w_cand;
            end
        end
    end

    // Most significant position of the new sample, so no leading zeros go out
    always_comb begin
        w_top_pos = '0;
        for (int k = 1; k < cpr_pkg::MAX_DIGITS; k++) begin
            if (cpr_pkg::CMP_W'(i_pend_sample) >= cpr_pkg::pow10(cpr_pkg::POS_W'(k))) begin
                w_top_pos = cpr_pkg::POS_W'(k);
            end
        end
    end

    always_comb begin
        n_ph        = r_ph;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_tx_byte   = r_tx_byte;
        n_last      = r_last;
        if (w_adv) begin
            n_last = 1'b0;
            unique case (r_ph)
                cpr_pkg::PH_IDLE: begin
                    n_out_valid = i_pend_valid;
                    if (i_pend_valid) begin
                        n_tx_byte = cpr_pkg::CH_BANG;
                        n_rem     = i_pend_sample;
                        n_pos     = w_top_pos;
                        n_idx     = cpr_pkg::IDX_W'(1);
                        n_ph      = cpr_pkg::PH_PREFIX;
                    end
                end
                cpr_pkg::PH_PREFIX: begin
                    n_out_valid = 1'b1;
                    n_tx_byte   = cpr_pkg::prefix_char(r_idx);
                    if (r_idx == cpr_pkg::PREFIX_LAST) begin
                        n_ph = cpr_pkg::PH_DIGIT;
                    end else begin
                        n_idx = r_idx + cpr_pkg::IDX_W'(1);
                    end
                end
                cpr_pkg::PH_DIGIT: begin
                    n_out_valid = 1'b1;
                    n_tx_byte   = cpr_pkg::CH_ZERO + {4'd0, w_digit};
                    n_rem       = SAMPLE_BITS'(w_rem_wide - w_sub);
                    if (r_pos == '0) begin
                        n_idx = '0;
                        n_ph  = cpr_pkg::PH_SUFFIX;
                    end else begin
                        n_pos = r_pos - cpr_pkg::POS_W'(1);
                    end
                end
                cpr_pkg::PH_SUFFIX: begin
                    n_out_valid = 1'b1;
                    n_tx_byte   = cpr_pkg::suffix_char(r_idx);
                    if (r_idx == cpr_pkg::SUFFIX_LAST) begin
                        n_last = 1'b1;
                        n_ph   = cpr_pkg::PH_IDLE;
                    end else begin
                        n_idx = r_idx + cpr_pkg::IDX_W'(1);
                    end
                end
                default: begin
                    n_out_valid = 1'b0;
                    n_ph        = cpr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= cpr_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_ph        <= n_ph;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_rem     <= n_rem;
        r_tx_byte <= n_tx_byte;
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_last_byte = r_last;

`ifndef ASSERT_OFF
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last |-> r_tx_byte == cpr_pkg::CH_LF)
        else $error("last byte is not a line feed");

    a_digit_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_ph == cpr_pkg::PH_DIGIT
        |=> r_tx_byte >= cpr_pkg::CH_ZERO && r_tx_byte <= cpr_pkg::CH_NINE)
        else $error("digit phase sent a non-digit");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_ph == cpr_pkg::PH_PREFIX && r_tx_byte == cpr_pkg::CH_BANG)
        else $error("response did not start with the prefix");
`endif

endmodule

`default_nettype wire

/* hw/rtl/command_parser_with_periodic_resend.sv */
`default_nettype none

// Command parser with periodic resend. Received bytes (op 0) drive a recognizer for
// "!RST#" and "!OK#"; timer ticks (op 1) drive the sender. After "!RST#", the next tick
// sends "!ADC=<decimal>#\r\n" for the current sample and keeps it; after each resend
// period of ticks is counted down, the tick after that sends the kept value again,
// until "!OK#". A request is accepted in every cycle while the one-entry response slot
// is free; a request that starts a response fills the slot until the serializer takes
// it. The serializer emits one character per cycle while the output is not stalled: a
// response of n digits holds n + 8 characters and the next one can follow with no gap, so
// a sending tick yields 9 to 12 characters with 12-bit samples (up to 13 with 16-bit samples).
// The resend period register is written through i_cfg_we / i_cfg_wdata; reset is 300.
module command_parser_with_periodic_resend #(
    parameter int SAMPLE_BITS = cpr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_op,
    input  wire logic [7:0]             i_rx_byte,
    input  wire logic [SAMPLE_BITS-1:0] i_adc_sample,
    input  wire logic                   i_cfg_we,
    input  wire logic [15:0]            i_cfg_wdata,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [7:0]                  o_tx_byte,
    output logic                        o_last_byte
);

    logic                   w_take;
    logic                   w_pend_valid;
    logic [SAMPLE_BITS-1:0] w_pend_sample;

    cpr_parser #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_rx_byte     (i_rx_byte),
        .i_adc_sample  (i_adc_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_take        (w_take),
        .o_pend_valid  (w_pend_valid),
        .o_pend_sample (w_pend_sample)
    );

    cpr_serializer #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pend_valid  (w_pend_valid),
        .i_pend_sample (w_pend_sample),
        .o_take        (w_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

`default_nettype wire

/* test/command_parser_checker.sv */
`timescale 1ns / 1ps

package cpr_tb_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

module command_parser_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic                                i_op,
    input  wire logic [7:0]                          i_rx_byte,
    input  wire logic [cpr_pkg::SAMPLE_BITS_DEF-1:0] i_adc_sample,
    input  wire logic                                i_cfg_we,
    input  wire logic [15:0]                         i_cfg_wdata,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic [7:0]                          i_tx_byte,
    input  wire logic                                i_last_byte,
    output int                                       o_mismatches,
    output int                                       o_outstanding
);

    localparam int SB = cpr_pkg::SAMPLE_BITS_DEF;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_reply_char;

    cpr_pkg::t_rz_state rz_st;
    cpr_pkg::t_sd_state sd_st;
    logic [SB-1:0] kept_adc;
    logic [15:0] ticks_left;
    logic [15:0] resend_period;
    t_reply_char reply_chars [$];
    int          reply_idx;

    initial o_mismatches = 0;

    task automatic flag_mismatch(input string what);
        // keep the log bounded when the block is badly broken
        if (o_mismatches < 100) $display("ERROR %0t ns: %s", $time, what);
        o_mismatches = o_mismatches + 1;
    endtask

    task automatic queue_reply(input logic [SB-1:0] value);
        logic [7:0]  text [$];
        logic [7:0]  digits [$];
        int unsigned v;
        t_reply_char c;
        v = value;
        text.push_back(cpr_pkg::CH_BANG);
        text.push_back(cpr_pkg::CH_A);
        text.push_back(cpr_pkg::CH_D);
        text.push_back(cpr_pkg::CH_C);
        text.push_back(cpr_pkg::CH_EQ);
        do begin
            digits.push_front(8'(cpr_pkg::CH_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) text.push_back(digits[i]);
        text.push_back(cpr_pkg::CH_HASH);
        text.push_back(cpr_pkg::CH_CR);
        text.push_back(cpr_pkg::CH_LF);
        foreach (text[i]) begin
            c.ch   = text[i];
            c.last = (i == text.size() - 1);
            reply_chars.push_back(c);
        end
    endtask

    task automatic recognize_byte(input logic [7:0] b);
        if (b == cpr_pkg::CH_BANG) begin
            rz_st = cpr_pkg::RZ_START;
        end else begin
            case (rz_st)
                cpr_pkg::RZ_START: begin
                    if (b == cpr_pkg::CH_R) rz_st = cpr_pkg::RZ_R;
                    else if (b == cpr_pkg::CH_O) rz_st = cpr_pkg::RZ_O;
                    else rz_st = cpr_pkg::RZ_IDLE;
                end
                cpr_pkg::RZ_R:
                    rz_st = (b == cpr_pkg::CH_S) ? cpr_pkg::RZ_RS : cpr_pkg::RZ_IDLE;
                cpr_pkg::RZ_RS:
                    rz_st = (b == cpr_pkg::CH_T) ? cpr_pkg::RZ_RST : cpr_pkg::RZ_IDLE;
                cpr_pkg::RZ_O:
                    rz_st = (b == cpr_pkg::CH_K) ? cpr_pkg::RZ_OK : cpr_pkg::RZ_IDLE;
                cpr_pkg::RZ_RST: begin
                    if (b == cpr_pkg::CH_HASH) sd_st = cpr_pkg::SD_SEND;
                    rz_st = cpr_pkg::RZ_IDLE;
                end
                cpr_pkg::RZ_OK: begin
                    if (b == cpr_pkg::CH_HASH) sd_st = cpr_pkg::SD_IDLE;
                    rz_st = cpr_pkg::RZ_IDLE;
                end
                default:  rz_st = cpr_pkg::RZ_IDLE;
            endcase
        end
    endtask

    task automatic sender_tick(input logic [SB-1:0] sample);
        case (sd_st)
            cpr_pkg::SD_SEND: begin
                queue_reply(sample);
                kept_adc   = sample;
                ticks_left = resend_period;
                sd_st      = cpr_pkg::SD_WAIT;
            end
            cpr_pkg::SD_WAIT: begin
                // zero period wraps to 65535 here
                ticks_left = ticks_left - 16'd1;
                if (ticks_left == 16'd0) sd_st = cpr_pkg::SD_RESEND;
            end
            cpr_pkg::SD_RESEND: begin
                queue_reply(kept_adc);
                ticks_left = resend_period;
                sd_st      = cpr_pkg::SD_WAIT;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : predict
        t_reply_char want;
        if (!i_rst_n) begin
            rz_st         = cpr_pkg::RZ_IDLE;
            sd_st         = cpr_pkg::SD_IDLE;
            kept_adc      = '0;
            ticks_left    = '0;
            resend_period = cpr_pkg::PERIOD_RESET;
            reply_idx     = 0;
            reply_chars.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (reply_chars.size() == 0) begin
                    flag_mismatch($sformatf("char %h with no reply pending", i_tx_byte));
                end else begin
                    want = reply_chars.pop_front();
                    if (i_tx_byte !== want.ch)
                        flag_mismatch($sformatf("char %0d: tx_byte %h, want %h",
                                                reply_idx, i_tx_byte, want.ch));
                    if (i_last_byte !== want.last)
                        flag_mismatch($sformatf("char %0d: last_byte %b, want %b",
                                                reply_idx, i_last_byte, want.last));
                end
                reply_idx++;
            end
            if (i_cfg_we) resend_period = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                if (i_op == cpr_tb_pkg::OP_TICK) sender_tick(i_adc_sample);
                else recognize_byte(i_rx_byte);
            end
        end
        o_outstanding = reply_chars.size();
    end

endmodule

/* test/tb_command_parser_with_periodic_resend.sv */
`timescale 1ns / 1ps

module tb_command_parser_with_periodic_resend;

    localparam int SB            = cpr_pkg::SAMPLE_BITS_DEF;
    localparam int MAX_GAP       = 18;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 260;
    localparam int DRAIN_LIMIT   = 5000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    logic          i_op;
    logic [7:0]    i_rx_byte;
    logic [SB-1:0] i_adc_sample;
    logic          i_cfg_we;
    logic [15:0]   i_cfg_wdata;
    logic          o_out_valid;
    logic          i_out_stall;
    logic [7:0]    o_tx_byte;
    logic          o_last_byte;

    int mismatches;
    int outstanding;
    int counted;
    bit no_idle;
    bit hold_off;

    command_parser_with_periodic_resend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_rx_byte   (i_rx_byte),
        .i_adc_sample(i_adc_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte)
    );

    command_parser_checker reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_rx_byte    (i_rx_byte),
        .i_adc_sample (i_adc_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_tx_byte    (o_tx_byte),
        .i_last_byte  (o_last_byte),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("command_parser_with_periodic_resend: mismatch");
        $finish;
    end

    // Reply side: random hold-off per char, plus one long hold on request.
    initial begin : reply_sink
        int gap;
        i_out_stall = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            // around the points where the digit count changes
            2:       return SB'(10 ** $urandom_range(1, 3));
            3:       return SB'(10 ** $urandom_range(1, 3) - 1);
            default: return SB'($urandom_range(0, (1 << SB) - 1));
        endcase
    endfunction

    task automatic offer_request(input logic op, input logic [7:0] rx,
                                 input logic [SB-1:0] adc);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_rx_byte    <= rx;
        i_adc_sample <= adc;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    task automatic send_byte(input logic [7:0] b);
        offer_request(cpr_tb_pkg::OP_BYTE, b, SB'($urandom_range(0, (1 << SB) - 1)));
    endtask

    task automatic send_tick(input logic [SB-1:0] sample);
        offer_request(cpr_tb_pkg::OP_TICK, 8'($urandom_range(0, 255)), sample);
    endtask

    task automatic send_cmd(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_period(input logic [15:0] ticks);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_mix(input int n);
        int    done_items;
        int    r;
        int    len;
        string cmd;
        done_items = 0;
        while (done_items < n) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_cmd("!RST#");
                done_items += 5;
            end else if (r < 40) begin
                send_cmd("!OK#");
                done_items += 4;
            end else if (r < 55) begin
                // command cut short by a wrong byte, sometimes a fresh '!'
                if (r[0]) cmd = "!RST#";
                else cmd = "!OK#";
                len = $urandom_range(1, cmd.len() - 1);
                for (int i = 0; i < len; i++) send_byte(cmd[i]);
                if ($urandom_range(0, 3) == 0) send_byte(cpr_pkg::CH_BANG);
                else send_byte(8'($urandom_range(0, 255)));
                done_items += len + 1;
            end else if (r < 62) begin
                send_byte(8'($urandom_range(0, 255)));
                done_items += 1;
            end else begin
                len = $urandom_range(1, 6);
                repeat (len) send_tick(pick_sample());
                done_items += len;
            end
        end
        counted += done_items;
    endtask

    initial begin : stimulus
        int phase;
        int n;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = cpr_tb_pkg::OP_BYTE;
        i_rx_byte    = '0;
        i_adc_sample = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        no_idle      = 1'b0;
        hold_off     = 1'b0;
        counted      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_period(16'd2);
        send_tick(pick_sample());           // nothing armed yet
        send_byte(8'h00);
        send_byte(8'hFF);
        send_cmd("x!RST#");
        send_tick('1);
        repeat (3) send_tick(pick_sample()); // count down twice, then resend
        send_cmd("!RST#");                   // rearm while counting
        send_tick('0);
        send_cmd("!!OK#");
        send_tick(pick_sample());

        for (phase = 0; counted < RANDOM_ITEMS; phase++) begin
            if (phase == 2) begin
                // reply side blocked while ticks keep coming
                set_period(16'd1);
                no_idle  = 1'b1;
                hold_off = 1'b1;
                send_cmd("!RST#");
                repeat (40) send_tick(pick_sample());
                send_cmd("!OK#");
                no_idle  = 1'b0;
                counted += 49;
            end
            if (phase == 4) begin
                // zero period: the count wraps, so no resend follows these ticks
                set_period(16'd0);
                send_cmd("!RST#");
                repeat (4) send_tick(pick_sample());
                send_cmd("!OK#");
                counted += 13;
            end
            if (phase == 1) set_period(16'hFFFF);
            else if (phase % 5 == 3) set_period(16'($urandom_range(1, 65535)));
            else set_period(16'($urandom_range(1, 6)));
            no_idle = ($urandom_range(0, 3) == 0);
            random_mix(40);
            no_idle = 1'b0;
        end

        i_in_valid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && outstanding != 0; n++) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("command_parser_with_periodic_resend: match");
        end else begin
            $display("command_parser_with_periodic_resend: mismatch");
        end
        $finish;
    end

endmodule
